// ===== src/rxs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxs_pkg
// Shared widths, codes and types for the record exchange sort block.
// ----------------------------------------------------------------------------
package rxs_pkg;

   localparam int DEPTH_DEF = 64;

   localparam int MODE_W  = 2;
   localparam int POS_W   = 7;
   localparam int SCORE_W = 10;
   localparam int ID_W    = 7;
   localparam int SUM_W   = 12;

   localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SORT    = 2'd2;

   // one stored record: id, three scores and their sum
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] sa;
      logic [SCORE_W-1:0] sb;
      logic [SCORE_W-1:0] sc;
      logic [SUM_W-1:0]   sum;
   } rec_type;

   // microcode control word
   typedef struct packed {
      logic       accept;   // take an input item
      logic [1:0] rd_sel;   // read address source
      logic       ld_cur;   // load the held record from read data
      logic       set_j;    // j = i + 1
      logic       cmp_j;    // compare held record with entry j, swap if smaller
      logic       wr_i;     // write held record back at i, advance i
      logic       emit;     // load the result register, advance k
      logic       clr_cnt;  // empty the store
      logic [2:0] cond;     // jump condition
      logic [3:0] target;   // jump target
   } uc_word_type;

endpackage
`default_nettype wire

// ===== src/rxs_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxs_req_if
// Input channel: command items with mode, position and three scores.
// ----------------------------------------------------------------------------
interface rxs_req_if;
   logic                                valid;
   logic                                ready;
   logic [rxs_pkg::MODE_W-1:0]          mode;
   logic [rxs_pkg::POS_W-1:0]           position;
   logic [rxs_pkg::SCORE_W-1:0]         score_a;
   logic [rxs_pkg::SCORE_W-1:0]         score_b;
   logic [rxs_pkg::SCORE_W-1:0]         score_c;

   modport source (output valid, output mode, output position,
                   output score_a, output score_b, output score_c, input ready);
   modport sink   (input valid, input mode, input position,
                   input score_a, input score_b, input score_c, output ready);
endinterface
`default_nettype wire

// ===== src/rxs_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxs_rsp_if
// Result channel: sorted records with id, scores and an end-of-run mark.
// ----------------------------------------------------------------------------
interface rxs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rxs_pkg::ID_W-1:0]            record_id;
   logic [rxs_pkg::SCORE_W-1:0]         out_a;
   logic [rxs_pkg::SCORE_W-1:0]         out_b;
   logic [rxs_pkg::SCORE_W-1:0]         out_c;
   logic                                last;

   modport source (output valid, output record_id, output out_a, output out_b,
                   output out_c, output last, input ready);
   modport sink   (input valid, input record_id, input out_a, input out_b,
                   input out_c, input last, output ready);
endinterface
`default_nettype wire

// ===== src/record_exchange_sort_by_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Append and replace items: one per cycle, written to the store in the cycle of acceptance.
// Sort item: exchange sort by sum; each compare step reads entry j, then compares it
// with the held record. Each result then waits for a free output register before it is loaded.
// Input is not accepted while a sort runs. Results leave through an output register.
// Reset (synchronous): record count, sequencer and result valid clear; store contents
// stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// record_exchange_sort_by_sum
// Record store with a microcoded exchange sort by score sum and sorted readout.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_sum #(
   parameter int DEPTH = rxs_pkg::DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   rxs_req_if.sink      req_chan,
   rxs_rsp_if.source    rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // sequencer steps
   localparam logic [3:0] ST_WAIT   = 4'd0;
   localparam logic [3:0] ST_TEST_I = 4'd1;
   localparam logic [3:0] ST_LOAD_I = 4'd2;
   localparam logic [3:0] ST_READ_J = 4'd3;
   localparam logic [3:0] ST_CMP_J  = 4'd4;
   localparam logic [3:0] ST_STORE  = 4'd5;
   localparam logic [3:0] ST_READ_K = 4'd6;
   localparam logic [3:0] ST_WAIT_O = 4'd7;
   localparam logic [3:0] ST_EMIT   = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   // jump conditions
   localparam logic [2:0] C_NEVER    = 3'd0;
   localparam logic [2:0] C_ALWAYS   = 3'd1;
   localparam logic [2:0] C_NO_SORT  = 3'd2;
   localparam logic [2:0] C_I_DONE   = 3'd3;
   localparam logic [2:0] C_J_MORE   = 3'd4;
   localparam logic [2:0] C_OUT_BUSY = 3'd5;
   localparam logic [2:0] C_K_MORE   = 3'd6;

   // read address sources
   localparam logic [1:0] RD_I = 2'd0;
   localparam logic [1:0] RD_J = 2'd1;
   localparam logic [1:0] RD_K = 2'd2;

   function automatic rxs_pkg::uc_word_type uc_rom(input logic [3:0] s);
      rxs_pkg::uc_word_type w;
      w = '0;
      case (s)
         ST_WAIT: begin
            w.accept = 1'b1; w.cond = C_NO_SORT; w.target = ST_WAIT;
         end
         ST_TEST_I: begin
            w.rd_sel = RD_I; w.set_j = 1'b1; w.cond = C_I_DONE; w.target = ST_READ_K;
         end
         ST_LOAD_I: begin
            w.ld_cur = 1'b1; w.cond = C_NEVER;
         end
         ST_READ_J: begin
            w.rd_sel = RD_J; w.cond = C_NEVER;
         end
         ST_CMP_J: begin
            w.rd_sel = RD_J; w.cmp_j = 1'b1; w.cond = C_J_MORE; w.target = ST_READ_J;
         end
         ST_STORE: begin
            w.wr_i = 1'b1; w.cond = C_ALWAYS; w.target = ST_TEST_I;
         end
         ST_READ_K: begin
            w.rd_sel = RD_K; w.cond = C_NEVER;
         end
         ST_WAIT_O: begin
            w.rd_sel = RD_K; w.cond = C_OUT_BUSY; w.target = ST_WAIT_O;
         end
         ST_EMIT: begin
            w.rd_sel = RD_K; w.emit = 1'b1; w.cond = C_K_MORE; w.target = ST_READ_K;
         end
         ST_DONE: begin
            w.clr_cnt = 1'b1; w.cond = C_ALWAYS; w.target = ST_WAIT;
         end
         default: begin
            w.cond = C_ALWAYS; w.target = ST_WAIT;
         end
      endcase
      return w;
   endfunction

   rxs_pkg::rec_type mem [DEPTH];

   logic [3:0]                    step_ff, step_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 i_ff, i_in;
   logic [CW-1:0]                 j_ff, j_in;
   logic [CW-1:0]                 k_ff, k_in;
   rxs_pkg::rec_type              cur_ff, cur_in;
   rxs_pkg::rec_type              rd_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rxs_pkg::rec_type              rsp_rec_ff, rsp_rec_in;
   logic                          rsp_last_ff, rsp_last_in;

   rxs_pkg::uc_word_type          uc;
   logic                          req_fire;
   logic                          sort_go;
   logic                          do_append;
   logic                          do_replace;
   logic                          out_free;
   logic                          swap;
   logic                          take;
   logic [CW-1:0]                 i_inc, j_inc, k_inc;
   logic [CW:0]                   cnt_inc;
   logic [AW-1:0]                 rd_addr;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   rxs_pkg::rec_type              wr_data;
   logic [rxs_pkg::SUM_W-1:0]     in_sum;

   assign uc       = uc_rom(step_ff);
   assign req_fire = req_chan.valid && uc.accept;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign i_inc    = i_ff + CW'(1);
   assign j_inc    = j_ff + CW'(1);
   assign k_inc    = k_ff + CW'(1);
   assign cnt_inc  = {1'b0, count_ff} + (CW + 1)'(1);
   assign swap     = uc.cmp_j && (rd_data_ff.sum < cur_ff.sum);

   assign sort_go    = req_fire && (req_chan.mode == rxs_pkg::MODE_SORT) && (count_ff != '0);
   assign do_append  = req_fire && (req_chan.mode == rxs_pkg::MODE_APPEND)
                       && (32'(count_ff) < DEPTH);
   assign do_replace = req_fire && (req_chan.mode == rxs_pkg::MODE_REPLACE)
                       && (req_chan.position != '0)
                       && (32'(req_chan.position) <= 32'(count_ff));

   assign in_sum = rxs_pkg::SUM_W'(req_chan.score_a) + rxs_pkg::SUM_W'(req_chan.score_b)
                   + rxs_pkg::SUM_W'(req_chan.score_c);

   // sequencer branch
   always_comb begin
      case (uc.cond)
         C_NEVER:    take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_SORT:  take = !sort_go;
         C_I_DONE:   take = !(i_inc < count_ff);
         C_J_MORE:   take = j_inc < count_ff;
         C_OUT_BUSY: take = !out_free;
         C_K_MORE:   take = k_inc < count_ff;
         default:    take = 1'b0;
      endcase
      step_in = take ? uc.target : step_ff + 4'd1;
   end

   always_comb begin
      case (uc.rd_sel)
         RD_I:    rd_addr = i_ff[AW-1:0];
         RD_J:    rd_addr = j_ff[AW-1:0];
         RD_K:    rd_addr = k_ff[AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   // single write port: commands in the wait step, swaps and write-back in the sort
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = cur_ff;
      if (do_append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = '{id: rxs_pkg::ID_W'(cnt_inc), sa: req_chan.score_a,
                     sb: req_chan.score_b, sc: req_chan.score_c, sum: in_sum};
      end else if (do_replace) begin
         // between sorts the record at position p always carries id p
         wr_en   = 1'b1;
         wr_addr = AW'(req_chan.position - rxs_pkg::POS_W'(1));
         wr_data = '{id: rxs_pkg::ID_W'(req_chan.position), sa: req_chan.score_a,
                     sb: req_chan.score_b, sc: req_chan.score_c, sum: in_sum};
      end else if (swap) begin
         wr_en   = 1'b1;
         wr_addr = j_ff[AW-1:0];
      end else if (uc.wr_i) begin
         wr_en   = 1'b1;
         wr_addr = i_ff[AW-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_append) begin
         count_in = cnt_inc[CW-1:0];
      end else if (uc.clr_cnt) begin
         count_in = '0;
      end

      i_in = i_ff;
      k_in = k_ff;
      if (sort_go) begin
         i_in = '0;
         k_in = '0;
      end else begin
         if (uc.wr_i) begin
            i_in = i_inc;
         end
         if (uc.emit) begin
            k_in = k_inc;
         end
      end

      j_in = j_ff;
      if (uc.set_j) begin
         j_in = i_inc;
      end else if (uc.cmp_j) begin
         j_in = j_inc;
      end

      cur_in = cur_ff;
      if (uc.ld_cur || swap) begin
         cur_in = rd_data_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      if (uc.emit) begin
         rsp_valid_in = 1'b1;
         rsp_rec_in   = rd_data_ff;
         rsp_last_in  = !(k_inc < count_ff);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_WAIT;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_chan.ready     = uc.accept;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.record_id = rsp_rec_ff.id;
   assign rsp_chan.out_a     = rsp_rec_ff.sa;
   assign rsp_chan.out_b     = rsp_rec_ff.sb;
   assign rsp_chan.out_c     = rsp_rec_ff.sc;
   assign rsp_chan.last      = rsp_last_ff;

endmodule
`default_nettype wire
